// ----- rtl/lmfc_pkg.sv -----
`timescale 1ns / 1ps

package lmfc_pkg;

	typedef logic [7:0] byte_t;

	// Operation codes carried by an input item.
	localparam logic [2:0] OP_WRITE   = 3'd0;
	localparam logic [2:0] OP_READ    = 3'd1;
	localparam logic [2:0] OP_TX_DONE = 3'd2;
	localparam logic [2:0] OP_RX_BYTE = 3'd3;
	localparam logic [2:0] OP_FETCH   = 3'd4;
	localparam logic [2:0] OP_DEINIT  = 3'd5;
	localparam logic [2:0] OP_INIT    = 3'd6;

	// Result kinds.
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_TX     = 2'd1;
	localparam logic [1:0] KIND_RX     = 2'd2;

	// Receiver control requests.
	localparam logic [1:0] RCTL_NONE    = 2'd0;
	localparam logic [1:0] RCTL_ENABLE  = 2'd1;
	localparam logic [1:0] RCTL_DISABLE = 2'd2;

	// Bus modes.
	localparam logic [1:0] MODE_IDLE      = 2'd0;
	localparam logic [1:0] MODE_READY     = 2'd1;
	localparam logic [1:0] MODE_SENDING   = 2'd2;
	localparam logic [1:0] MODE_RECEIVING = 2'd3;

	// Configuration register indexes.
	localparam logic [0:0] REG_DIAG_TX_ID  = 1'b0;
	localparam logic [0:0] REG_DIAG_RX_PID = 1'b1;

	localparam logic [5:0] DIAG_TX_ID_RST  = 6'd60;
	localparam byte_t      DIAG_RX_PID_RST = 8'h7D;
	localparam byte_t      SYNC_BYTE       = 8'h55;

	// Largest number of data bytes streamed for one fetch.
	localparam int MAX_RESULTS = 11;

	// A single pending result that is not part of a data stream.
	typedef struct packed {
		logic [1:0] kind;
		byte_t      data;
		logic       brk;
		logic [1:0] rctl;
	} result_t;

endpackage

// ----- rtl/lin_master_frame_controller.sv -----
`timescale 1ns / 1ps
// A plain item goes to the output state and its single result is registered on the way out.
// A fetch passes through the checksum lanes (ST_WORK) and the compare (ST_CHECK); its data
// bytes then stream from ST_OUT, one byte per cycle while res_ready takes them.
// The block takes no new item until the last result of the current one is loaded, so the
// single result register paces it; a fetch streams N bytes, N at most 11.
// Reset (arst_n, asynchronous): bus ready, counters and frame state cleared.
module lin_master_frame_controller #(
	parameter int MAX_DATA = 8,
	parameter int RX_DEPTH = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  op,
	input  logic [5:0]  node_id,
	input  logic [3:0]  length,
	input  logic [7:0]  tx_data_0,
	input  logic [7:0]  tx_data_1,
	input  logic [7:0]  tx_data_2,
	input  logic [7:0]  tx_data_3,
	input  logic [7:0]  tx_data_4,
	input  logic [7:0]  tx_data_5,
	input  logic [7:0]  tx_data_6,
	input  logic [7:0]  tx_data_7,
	input  logic [7:0]  uart_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic        send_break,
	output logic [1:0]  receive_ctrl,
	output logic [3:0]  rx_length,
	output logic        checksum_ok,
	output logic [1:0]  bus_state,
	output logic        last
);
	import lmfc_pkg::*;

	localparam int TX_AW    = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
	localparam int RX_AW    = $clog2(RX_DEPTH);
	localparam int RXC_W    = $clog2(RX_DEPTH + 1);
	localparam int RX_LANES = RX_DEPTH - 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WORK  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	// Protected id: six id bits plus two parity bits.
	function automatic byte_t make_pid(input logic [5:0] id);
		return {~(id[1] ^ id[3] ^ id[4] ^ id[5]), id[0] ^ id[1] ^ id[2] ^ id[4], id};
	endfunction

	logic [1:0]       state_q;
	logic [1:0]       mode_q;
	logic [3:0]       step_q;
	logic [RXC_W-1:0] rxcnt_q;
	byte_t            fpid_q;
	byte_t            fseed_q;
	logic [3:0]       flen_q;
	byte_t            rpid_q;
	logic [5:0]       diag_tx_q;
	byte_t            diag_rx_q;
	logic [RX_AW-1:0] fdl_q;
	logic             fvalid_q;
	result_t          res_q;
	logic             str_q;
	logic [RX_AW-1:0] str_idx_q;
	logic [RX_AW-1:0] str_end_q;
	byte_t            rd_q;
	logic             res_valid_q;

	logic [1:0]       kind_q;
	byte_t            byte_q;
	logic             brk_q;
	logic [1:0]       rctl_q;
	logic [3:0]       rlen_q;
	logic             ok_q;
	logic [1:0]       bus_q;
	logic             last_q;

	byte_t tx_store [MAX_DATA];
	byte_t rx_store [RX_DEPTH];

	byte_t                     txd [8];
	logic                      accept;
	logic                      out_free;
	logic                      out_load;
	logic                      wr_take;
	logic                      rx_take;
	logic [3:0]                len_sat;
	byte_t                     pid_in;
	logic [3:0]                tidx;
	byte_t                     tx_rd;
	logic [RX_AW-1:0]          rd_addr;
	byte_t                     rx_rd;
	logic [4:0]                dl_w;
	byte_t                     tx_csum;
	byte_t                     rx_csum;
	byte_t                     rx_seed;
	byte_t [MAX_DATA-1:0]      tx_lane_byte;
	logic  [MAX_DATA-1:0]      tx_lane_en;
	byte_t [RX_LANES-1:0]      rx_lane_byte;
	logic  [RX_LANES-1:0]      rx_lane_en;

	assign txd[0] = tx_data_0;
	assign txd[1] = tx_data_1;
	assign txd[2] = tx_data_2;
	assign txd[3] = tx_data_3;
	assign txd[4] = tx_data_4;
	assign txd[5] = tx_data_5;
	assign txd[6] = tx_data_6;
	assign txd[7] = tx_data_7;

	// Handshake and request decode.
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !res_valid_q || res_ready;
	assign out_load   = (state_q == ST_OUT) && out_free;
	assign len_sat    = (length > 4'(MAX_DATA)) ? 4'(MAX_DATA) : length;
	assign pid_in     = make_pid(node_id);
	assign wr_take    = (op == OP_WRITE) && (mode_q == MODE_READY) && (length != 4'd0);
	assign rx_take    = (op == OP_RX_BYTE) && (mode_q == MODE_RECEIVING)
		&& !((rxcnt_q == '0) && (uart_byte == rpid_q))
		&& (rxcnt_q < RXC_W'(RX_DEPTH));

	// Transmit data byte for the current step.
	assign tidx  = step_q - 4'd2;
	assign tx_rd = tx_store[tidx[TX_AW-1:0]];

	// One read port on the receive store: the checksum byte, then the stream.
	assign rd_addr = (state_q == ST_WORK) ? fdl_q : str_idx_q;
	assign rx_rd   = rx_store[rd_addr];
	assign dl_w    = 5'(fdl_q);

	// Lane inputs: each lane looks at one fixed store entry.
	always_comb begin
		for (int j = 0; j < MAX_DATA; j++) begin
			tx_lane_byte[j] = tx_store[j];
			tx_lane_en[j]   = (4'(j) < flen_q);
		end
		for (int j = 0; j < RX_LANES; j++) begin
			rx_lane_byte[j] = rx_store[j];
			rx_lane_en[j]   = (RX_AW'(j) < fdl_q);
		end
	end

	assign rx_seed = (rpid_q == diag_rx_q) ? 8'h00 : rpid_q;

	lmfc_csum_lanes #(
		.LANES (MAX_DATA)
	) u_tx_lanes (
		.clk       (clk),
		.lane_byte (tx_lane_byte),
		.lane_en   (tx_lane_en),
		.seed      (fseed_q),
		.csum_s1   (tx_csum)
	);

	lmfc_csum_lanes #(
		.LANES (RX_LANES)
	) u_rx_lanes (
		.clk       (clk),
		.lane_byte (rx_lane_byte),
		.lane_en   (rx_lane_en),
		.seed      (rx_seed),
		.csum_s1   (rx_csum)
	);

	// Data stores and the registered checksum byte.
	always_ff @(posedge clk) begin
		if (accept && wr_take) begin
			for (int j = 0; j < MAX_DATA; j++) begin
				tx_store[j] <= txd[j];
			end
		end
		if (accept && rx_take) begin
			rx_store[rxcnt_q[RX_AW-1:0]] <= uart_byte;
		end
		if (state_q == ST_WORK) begin
			rd_q <= rx_rd;
		end
	end

	// Sequencer and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_READY;
			step_q      <= '0;
			rxcnt_q     <= '0;
			fpid_q      <= '0;
			fseed_q     <= '0;
			flen_q      <= '0;
			rpid_q      <= '0;
			diag_tx_q   <= DIAG_TX_ID_RST;
			diag_rx_q   <= DIAG_RX_PID_RST;
			fdl_q       <= '0;
			fvalid_q    <= 1'b0;
			res_q       <= '0;
			str_q       <= 1'b0;
			str_idx_q   <= '0;
			str_end_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DIAG_TX_ID:  diag_tx_q <= cfg_data[5:0];
					REG_DIAG_RX_PID: diag_rx_q <= cfg_data;
					default: ;
				endcase
			end

			if (res_valid_q && res_ready && !out_load) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						str_q   <= 1'b0;
						state_q <= (op == OP_FETCH) ? ST_WORK : ST_OUT;
						case (op)
							OP_WRITE: begin
								if (wr_take) begin
									fpid_q  <= pid_in;
									flen_q  <= len_sat;
									fseed_q <= (node_id == diag_tx_q) ? 8'h00 : pid_in;
									step_q  <= '0;
									mode_q  <= MODE_SENDING;
									res_q   <= '{KIND_TX, 8'h00, 1'b1, RCTL_NONE};
								end else begin
									res_q   <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_NONE};
								end
							end
							OP_READ: begin
								if (mode_q == MODE_READY) begin
									mode_q  <= MODE_RECEIVING;
									step_q  <= '0;
									rxcnt_q <= '0;
									rpid_q  <= pid_in;
									res_q   <= '{KIND_TX, 8'h00, 1'b1, RCTL_NONE};
								end else begin
									res_q   <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_NONE};
								end
							end
							OP_TX_DONE: begin
								if (step_q != 4'd15) begin
									step_q <= step_q + 4'd1;
								end
								if (mode_q == MODE_SENDING) begin
									if (step_q == 4'd0) begin
										res_q <= '{KIND_TX, SYNC_BYTE, 1'b0, RCTL_NONE};
									end else if (step_q == 4'd1) begin
										res_q <= '{KIND_TX, fpid_q, 1'b0, RCTL_NONE};
									end else if (tidx < flen_q) begin
										res_q <= '{KIND_TX, tx_rd, 1'b0, RCTL_NONE};
									end else if (tidx == flen_q) begin
										res_q <= '{KIND_TX, tx_csum, 1'b0, RCTL_NONE};
									end else begin
										mode_q <= MODE_READY;
										res_q  <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_NONE};
									end
								end else if (mode_q == MODE_RECEIVING) begin
									if (step_q == 4'd0) begin
										res_q <= '{KIND_TX, SYNC_BYTE, 1'b0, RCTL_NONE};
									end else if (step_q == 4'd1) begin
										res_q <= '{KIND_TX, rpid_q, 1'b0, RCTL_NONE};
									end else begin
										res_q <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_ENABLE};
									end
								end else begin
									res_q <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_NONE};
								end
							end
							OP_RX_BYTE: begin
								if (rx_take) begin
									rxcnt_q <= rxcnt_q + RXC_W'(1);
								end
								res_q <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_NONE};
							end
							OP_FETCH: begin
								fdl_q    <= RX_AW'(rxcnt_q - RXC_W'(1));
								fvalid_q <= (rxcnt_q > RXC_W'(1));
								rxcnt_q  <= '0;
								mode_q   <= MODE_READY;
							end
							OP_DEINIT: begin
								mode_q <= MODE_IDLE;
								res_q  <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_NONE};
							end
							OP_INIT: begin
								rxcnt_q <= '0;
								step_q  <= '0;
								mode_q  <= MODE_READY;
								res_q   <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_DISABLE};
							end
							default: begin
								res_q <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_NONE};
							end
						endcase
					end
				end
				ST_WORK: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					// A valid frame streams its data; otherwise one status item.
					state_q <= ST_OUT;
					if (fvalid_q && (rx_csum == rd_q)) begin
						str_q     <= 1'b1;
						str_idx_q <= '0;
						str_end_q <= (dl_w > 5'(MAX_RESULTS)) ? RX_AW'(MAX_RESULTS - 1)
							: RX_AW'(dl_w - 5'd1);
					end else begin
						str_q <= 1'b0;
						res_q <= '{KIND_STATUS, 8'h00, 1'b0, RCTL_DISABLE};
					end
				end
				ST_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						if (str_q && (str_idx_q != str_end_q)) begin
							str_idx_q <= str_idx_q + RX_AW'(1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			bus_q <= mode_q;
			if (str_q) begin
				kind_q <= KIND_RX;
				byte_q <= rx_rd;
				brk_q  <= 1'b0;
				rctl_q <= RCTL_DISABLE;
				rlen_q <= 4'(fdl_q);
				ok_q   <= 1'b1;
				last_q <= (str_idx_q == str_end_q);
			end else begin
				kind_q <= res_q.kind;
				byte_q <= res_q.data;
				brk_q  <= res_q.brk;
				rctl_q <= res_q.rctl;
				rlen_q <= 4'd0;
				ok_q   <= 1'b0;
				last_q <= 1'b1;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign kind         = kind_q;
	assign out_byte     = byte_q;
	assign send_break   = brk_q;
	assign receive_ctrl = rctl_q;
	assign rx_length    = rlen_q;
	assign checksum_ok  = ok_q;
	assign bus_state    = bus_q;
	assign last         = last_q;

	// The receive count never passes the store depth.
	a_rxcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rxcnt_q <= RXC_W'(RX_DEPTH))
		else $error("receive count beyond store depth");

	// A frame being sent always has a legal data length.
	a_send_len: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_SENDING) |-> ((flen_q != 4'd0) && (flen_q <= 4'(MAX_DATA))))
		else $error("sending with an illegal frame length");

	// A fetch leaves the bus ready with an empty receive count and starts the lanes.
	a_fetch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_FETCH)) |=>
		((mode_q == MODE_READY) && (rxcnt_q == '0) && (state_q == ST_WORK)))
		else $error("fetch did not clear the receive state");

	// The stream index stays within the validated count.
	a_stream_idx: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && str_q) |-> (str_idx_q <= str_end_q))
		else $error("stream index past its end");

	// Only a data stream produces items that are not the last of their request.
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !last) |-> (kind == KIND_RX))
		else $error("non-final item outside a data stream");

endmodule

// ----- rtl/lmfc_csum_lanes.sv -----
`timescale 1ns / 1ps

module lmfc_csum_lanes #(
	parameter int LANES = 8
) (
	input  logic                          clk,
	input  lmfc_pkg::byte_t [LANES-1:0]   lane_byte,
	input  logic [LANES-1:0]              lane_en,
	input  lmfc_pkg::byte_t               seed,
	output lmfc_pkg::byte_t               csum_s1
);
	import lmfc_pkg::*;

	// The seed takes one leaf, each lane one more; the tree is padded to a power of two.
	localparam int LEAVES = 1 << $clog2(LANES + 1);

	byte_t node [1:2*LEAVES-1];

	// Add with the carry folded back in. This is associative, so a tree
	// gives the same answer as a running sum.
	function automatic byte_t fold_add(input byte_t a, input byte_t b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? (s[7:0] + 8'd1) : s[7:0];
	endfunction

	// Each lane passes its byte only when it lies inside the frame.
	assign node[LEAVES] = seed;

	genvar g;
	generate
		for (g = 0; g < LEAVES - 1; g++) begin : g_leaf
			if (g < LANES) begin : g_lane
				assign node[LEAVES+1+g] = lane_en[g] ? lane_byte[g] : 8'h00;
			end else begin : g_pad
				assign node[LEAVES+1+g] = 8'h00;
			end
		end
		for (g = 1; g < LEAVES; g++) begin : g_merge
			assign node[g] = fold_add(node[2*g], node[2*g+1]);
		end
	endgenerate

	// Merging stage: the inverted total is registered.
	always_ff @(posedge clk) begin
		csum_s1 <= ~node[1];
	end

endmodule

// ----- bench/tb_lin_master_frame_controller.sv -----
`timescale 1ns / 1ps

module tb_lin_master_frame_controller;

	import lmfc_pkg::*;

	localparam int LIN_MAX_DATA = 8;
	localparam int LIN_RX_DEPTH = 12;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// One input item as the block sees it.
	typedef struct packed {
		logic [2:0]      op;
		logic [5:0]      node_id;
		logic [3:0]      length;
		logic [7:0][7:0] txd;
		logic [7:0]      uart_byte;
	} item_t;

	// One result item, fields in port order.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       brk;
		logic [1:0] rctl;
		logic [3:0] rlen;
		logic       ok;
		logic [1:0] bstate;
		logic       last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;
	logic item_valid = 1'b0;
	logic item_ready;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic send_break;
	logic [1:0] receive_ctrl;
	logic [3:0] rx_length;
	logic checksum_ok;
	logic [1:0] bus_state;
	logic last;
	item_t cur_item = '0;

	// Handshake bookkeeping between the edges.
	logic taken_tog = 1'b0;
	logic seen_tog = 1'b0;
	int send_idle_pct;
	int recv_idle_pct;
	int mismatches = 0;
	int stall_cycles = 0;
	int items_added = 0;

	item_t items_queued[$];
	res_t lin_results_due[$];
	res_t step_out[$];

	// Shadow of the frame sequencer.
	logic [5:0] diag_tx_cfg;
	logic [7:0] diag_rx_cfg;
	logic [1:0] lin_mode;
	logic [3:0] step_cnt;
	logic [3:0] rx_cnt;
	logic [7:0] frame_pid;
	logic [7:0] read_pid;
	logic [3:0] frame_len;
	logic [7:0] frame_cks;
	logic [15:0][7:0] tx_mem;
	logic [15:0][7:0] rx_mem;

	lin_master_frame_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.op(cur_item.op),
		.node_id(cur_item.node_id),
		.length(cur_item.length),
		.tx_data_0(cur_item.txd[0]),
		.tx_data_1(cur_item.txd[1]),
		.tx_data_2(cur_item.txd[2]),
		.tx_data_3(cur_item.txd[3]),
		.tx_data_4(cur_item.txd[4]),
		.tx_data_5(cur_item.txd[5]),
		.tx_data_6(cur_item.txd[6]),
		.tx_data_7(cur_item.txd[7]),
		.uart_byte(cur_item.uart_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.kind(kind),
		.out_byte(out_byte),
		.send_break(send_break),
		.receive_ctrl(receive_ctrl),
		.rx_length(rx_length),
		.checksum_ok(checksum_ok),
		.bus_state(bus_state),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Protected id: six id bits plus the two LIN parity bits.
	function automatic logic [7:0] pid_of(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

	// Byte sum with the carry folded back in, then inverted.
	function automatic logic [7:0] fold_sum(input logic [7:0] seed,
			input logic [15:0][7:0] bytes, input int n);
		int unsigned acc;
		int i;
		acc = seed;
		for (i = 0; i < n; i++) begin
			acc = acc + bytes[i];
			if (acc > 255)
				acc = acc - 255;
		end
		return 8'(~acc);
	endfunction

	task automatic emit(input logic [1:0] k, input logic [7:0] b, input logic brk,
			input logic [1:0] rc, input logic [3:0] rl, input logic ok);
		res_t r;
		r = {k, b, brk, rc, rl, ok, lin_mode, 1'b0};
		step_out.push_back(r);
	endtask

	// Works out the results that one accepted item causes.
	task automatic lin_frame_step(input item_t it);
		int i;
		int idx;
		int dl;
		int good;
		int cnt;
		logic [3:0] len;
		logic [7:0] seed;
		res_t r;
		case (it.op)
			OP_WRITE: begin
				if (lin_mode == MODE_READY && it.length != 4'd0) begin
					len = (it.length > LIN_MAX_DATA) ? 4'(LIN_MAX_DATA) : it.length;
					for (i = 0; i < LIN_MAX_DATA; i++)
						if (i < len)
							tx_mem[i] = it.txd[i];
					frame_pid = pid_of(it.node_id);
					frame_len = len;
					seed = (it.node_id == diag_tx_cfg) ? 8'h00 : frame_pid;
					frame_cks = fold_sum(seed, tx_mem, int'(len));
					step_cnt = 4'd0;
					lin_mode = MODE_SENDING;
					emit(KIND_TX, 8'h00, 1'b1, RCTL_NONE, 4'd0, 1'b0);
				end
			end
			OP_READ: begin
				if (lin_mode == MODE_READY) begin
					lin_mode = MODE_RECEIVING;
					step_cnt = 4'd0;
					rx_cnt = 4'd0;
					read_pid = pid_of(it.node_id);
					emit(KIND_TX, 8'h00, 1'b1, RCTL_NONE, 4'd0, 1'b0);
				end
			end
			OP_TX_DONE: begin
				if (lin_mode == MODE_SENDING) begin
					if (step_cnt == 4'd0) begin
						emit(KIND_TX, SYNC_BYTE, 1'b0, RCTL_NONE, 4'd0, 1'b0);
					end else if (step_cnt == 4'd1) begin
						emit(KIND_TX, frame_pid, 1'b0, RCTL_NONE, 4'd0, 1'b0);
					end else begin
						idx = int'(step_cnt) - 2;
						if (idx < frame_len)
							emit(KIND_TX, tx_mem[idx], 1'b0, RCTL_NONE, 4'd0, 1'b0);
						else if (idx == frame_len)
							emit(KIND_TX, frame_cks, 1'b0, RCTL_NONE, 4'd0, 1'b0);
						else
							lin_mode = MODE_READY;
					end
				end else if (lin_mode == MODE_RECEIVING) begin
					if (step_cnt == 4'd0)
						emit(KIND_TX, SYNC_BYTE, 1'b0, RCTL_NONE, 4'd0, 1'b0);
					else if (step_cnt == 4'd1)
						emit(KIND_TX, read_pid, 1'b0, RCTL_NONE, 4'd0, 1'b0);
					else
						emit(KIND_STATUS, 8'h00, 1'b0, RCTL_ENABLE, 4'd0, 1'b0);
				end
				// The step counter holds at its top value.
				if (step_cnt != 4'd15)
					step_cnt = step_cnt + 4'd1;
			end
			OP_RX_BYTE: begin
				// The PID echo is dropped only as the first byte of a frame.
				if (lin_mode == MODE_RECEIVING &&
						!(rx_cnt == 4'd0 && it.uart_byte == read_pid) &&
						rx_cnt < LIN_RX_DEPTH) begin
					rx_mem[rx_cnt] = it.uart_byte;
					rx_cnt = rx_cnt + 4'd1;
				end
			end
			OP_FETCH: begin
				good = 0;
				if (rx_cnt > 4'd1) begin
					dl = int'(rx_cnt) - 1;
					seed = (read_pid == diag_rx_cfg) ? 8'h00 : read_pid;
					if (fold_sum(seed, rx_mem, dl) == rx_mem[dl])
						good = dl;
				end
				rx_cnt = 4'd0;
				lin_mode = MODE_READY;
				if (good > 0) begin
					cnt = (good < MAX_RESULTS) ? good : MAX_RESULTS;
					for (i = 0; i < cnt; i++)
						emit(KIND_RX, rx_mem[i], 1'b0, RCTL_DISABLE, 4'(good), 1'b1);
				end else begin
					emit(KIND_STATUS, 8'h00, 1'b0, RCTL_DISABLE, 4'd0, 1'b0);
				end
			end
			OP_DEINIT: begin
				lin_mode = MODE_IDLE;
			end
			OP_INIT: begin
				rx_cnt = 4'd0;
				step_cnt = 4'd0;
				lin_mode = MODE_READY;
				emit(KIND_STATUS, 8'h00, 1'b0, RCTL_DISABLE, 4'd0, 1'b0);
			end
			default: begin
			end
		endcase
		// Every item answers at least once; the final result carries last.
		if (step_out.size() == 0)
			emit(KIND_STATUS, 8'h00, 1'b0, RCTL_NONE, 4'd0, 1'b0);
		for (i = 0; i < step_out.size(); i++) begin
			r = step_out[i];
			r.last = (i == step_out.size() - 1);
			lin_results_due.push_back(r);
		end
		step_out.delete();
	endtask

	task automatic report_bad(input string what, input res_t want, input res_t got);
		if (mismatches < 10) begin
			$display("%s at %0t", what, $realtime);
			$display("  expected kind=%0d byte=%02h brk=%0d rctl=%0d rlen=%0d ok=%0d state=%0d last=%0d",
				want.kind, want.out_byte, want.brk, want.rctl, want.rlen, want.ok,
				want.bstate, want.last);
			$display("  actual   kind=%0d byte=%02h brk=%0d rctl=%0d rlen=%0d ok=%0d state=%0d last=%0d",
				got.kind, got.out_byte, got.brk, got.rctl, got.rlen, got.ok,
				got.bstate, got.last);
		end
		mismatches++;
	endtask

	// Rising edge: predict accepted items, check accepted results, watch for a hang.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				lin_frame_step(cur_item);
				taken_tog = ~taken_tog;
			end
			if (res_valid && res_ready) begin
				got = {kind, out_byte, send_break, receive_ctrl, rx_length, checksum_ok,
					bus_state, last};
				if (lin_results_due.size() == 0) begin
					report_bad("unexpected result", '0, got);
				end else begin
					want = lin_results_due.pop_front();
					if (got !== want)
						report_bad("result mismatch", want, got);
				end
			end
			if ((item_valid && item_ready) || (res_valid && res_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Falling edge: present the next item and set the result backpressure.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || taken_tog != seen_tog) begin
				seen_tog = taken_tog;
				if (items_queued.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_item <= items_queued.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic item_t rand_item(input logic [2:0] code);
		item_t it;
		int i;
		it.op = code;
		it.node_id = 6'($urandom_range(0, 63));
		it.length = 4'($urandom_range(0, 15));
		for (i = 0; i < 8; i++)
			it.txd[i] = 8'($urandom);
		it.uart_byte = 8'($urandom);
		return it;
	endfunction

	task automatic push_item(input item_t it);
		items_queued.push_back(it);
		items_added++;
	endtask

	// Write request followed by the transmit-complete events that finish it.
	task automatic queue_write_frame();
		item_t it;
		int nbytes;
		it = rand_item(OP_WRITE);
		if ($urandom_range(0, 3) == 0)
			it.node_id = diag_tx_cfg;
		it.length = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(1, 8));
		push_item(it);
		nbytes = (it.length > LIN_MAX_DATA) ? LIN_MAX_DATA : int'(it.length);
		repeat (nbytes + 4)
			push_item(rand_item(OP_TX_DONE));
	endtask

	// Read request, header, received bytes and a fetch.
	task automatic queue_read_frame();
		item_t it;
		logic [15:0][7:0] body;
		logic [7:0] pid;
		logic [7:0] seed;
		int diag_id;
		int extra;
		int shape;
		int dl;
		int tail;
		int i;
		diag_id = -1;
		for (i = 0; i < 64; i++)
			if (pid_of(6'(i)) == diag_rx_cfg)
				diag_id = i;
		it = rand_item(OP_READ);
		if (diag_id >= 0 && $urandom_range(0, 2) == 0)
			it.node_id = 6'(diag_id);
		pid = pid_of(it.node_id);
		seed = (pid == diag_rx_cfg) ? 8'h00 : pid;
		push_item(it);
		extra = ($urandom_range(0, 19) == 0) ? 14 : $urandom_range(0, 2);
		repeat (2 + extra)
			push_item(rand_item(OP_TX_DONE));
		if ($urandom_range(0, 9) < 7) begin
			it = rand_item(OP_RX_BYTE);
			it.uart_byte = pid;
			push_item(it);
		end
		shape = $urandom_range(0, 99);
		if (shape < 30) begin
			dl = LIN_RX_DEPTH - 1;
			tail = (shape < 15) ? 0 : $urandom_range(1, 3);
		end else begin
			dl = $urandom_range(1, 8);
			tail = 0;
		end
		if (shape >= 30 && shape < 40) begin
			// Too short to validate: zero or one byte.
			repeat ($urandom_range(0, 1))
				push_item(rand_item(OP_RX_BYTE));
		end else begin
			for (i = 0; i < 16; i++)
				body[i] = 8'($urandom);
			body[dl] = fold_sum(seed, body, dl);
			if (shape >= 40 && shape < 50)
				body[dl] = body[dl] ^ 8'($urandom_range(1, 255));
			for (i = 0; i <= dl; i++) begin
				it = rand_item(OP_RX_BYTE);
				it.uart_byte = body[i];
				push_item(it);
			end
			// Bytes beyond a full store are dropped.
			repeat (tail)
				push_item(rand_item(OP_RX_BYTE));
		end
		push_item(rand_item(OP_FETCH));
	endtask

	// Mostly well-formed frames with random content, some noise in between.
	task automatic queue_random(input int n_items);
		int target;
		int pick;
		logic after_noise;
		target = items_added + n_items;
		after_noise = 1'b1;
		while (items_added < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				repeat ($urandom_range(1, 4))
					push_item(rand_item(3'($urandom_range(0, 7))));
				after_noise = 1'b1;
			end else begin
				if (after_noise || $urandom_range(0, 9) == 0)
					push_item(rand_item(OP_INIT));
				after_noise = 1'b0;
				if (pick < 60)
					queue_write_frame();
				else
					queue_read_frame();
			end
		end
	endtask

	task automatic drain();
		while (items_queued.size() != 0 || item_valid || lin_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Both registers are written only while the block is idle.
	task automatic set_regs(input logic [5:0] tx_id, input logic [7:0] rx_pid);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = REG_DIAG_TX_ID;
		cfg_data = {2'b00, tx_id};
		@(negedge clk);
		cfg_index = REG_DIAG_RX_PID;
		cfg_data = rx_pid;
		@(negedge clk);
		cfg_we = 1'b0;
		diag_tx_cfg = tx_id;
		diag_rx_cfg = rx_pid;
	endtask

	initial begin
		item_t it;
		logic [15:0][7:0] one_byte;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIAG_TX_ID;
		cfg_data = 8'h00;
		diag_tx_cfg = DIAG_TX_ID_RST;
		diag_rx_cfg = DIAG_RX_PID_RST;
		lin_mode = MODE_READY;
		step_cnt = 4'd0;
		rx_cnt = 4'd0;
		frame_pid = 8'h00;
		read_pid = 8'h00;
		frame_len = 4'd0;
		frame_cks = 8'h00;
		tx_mem = '0;
		rx_mem = '0;
		send_idle_pct = 27;
		recv_idle_pct = 75;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: unused op code with every field at its top value.
		it = rand_item(OP_UNUSED);
		it.node_id = 6'h3F;
		it.length = 4'hF;
		it.txd = '1;
		it.uart_byte = 8'hFF;
		push_item(it);
		// Transmit complete and a received byte while merely ready.
		push_item(rand_item(OP_TX_DONE));
		it = rand_item(OP_RX_BYTE);
		it.uart_byte = 8'h00;
		push_item(it);
		// An empty write is ignored.
		it = rand_item(OP_WRITE);
		it.length = 4'd0;
		push_item(it);
		// Oversized write on the classic-checksum id, saturated to eight bytes.
		it = rand_item(OP_WRITE);
		it.node_id = DIAG_TX_ID_RST;
		it.length = 4'hF;
		it.txd = 64'hFF00_FF00_FF00_FF00;
		push_item(it);
		// A read request while sending is ignored.
		push_item(rand_item(OP_READ));
		repeat (LIN_MAX_DATA + 4)
			push_item(rand_item(OP_TX_DONE));
		// Parked idle: a write is ignored, a fetch of nothing, then init.
		push_item(rand_item(OP_DEINIT));
		it = rand_item(OP_WRITE);
		it.length = 4'd1;
		push_item(it);
		push_item(rand_item(OP_FETCH));
		push_item(rand_item(OP_INIT));
		// Read on the diagnostic PID with echo and one byte, classic checksum.
		it = rand_item(OP_READ);
		it.node_id = DIAG_RX_PID_RST[5:0];
		push_item(it);
		repeat (3)
			push_item(rand_item(OP_TX_DONE));
		it = rand_item(OP_RX_BYTE);
		it.uart_byte = DIAG_RX_PID_RST;
		push_item(it);
		it.uart_byte = 8'h00;
		push_item(it);
		one_byte = '0;
		it.uart_byte = fold_sum(8'h00, one_byte, 1);
		push_item(it);
		push_item(rand_item(OP_FETCH));
		drain();

		// Random traffic under three register settings and idle profiles.
		set_regs(6'd0, 8'h00);
		queue_random(60);
		drain();

		send_idle_pct = 75;
		recv_idle_pct = 27;
		set_regs(6'd63, 8'hFF);
		queue_random(60);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_regs(6'd21, pid_of(6'd42));
		queue_random(60);
		drain();

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
